// ===== rtl/core/hvt_pkg.sv =====
// Shared types and constants of the homogeneous vertex transform.
package hvt_pkg;

   localparam int unsigned DIM    = 4;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned PROD_W = 2 * DATA_W;
   // Four products of 64 bits sum exactly in 66 bits.
   localparam int unsigned SUM_W  = PROD_W + 2;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_XFORM = 1'b1;

   localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

   typedef struct packed {
      logic              action;
      logic [1:0]        row;
      logic [1:0]        col;
      logic [DATA_W-1:0] coef;
      logic [DATA_W-1:0] in_x;
      logic [DATA_W-1:0] in_y;
      logic [DATA_W-1:0] in_z;
      logic [DATA_W-1:0] in_w;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] out_x;
      logic [DATA_W-1:0] out_y;
      logic [DATA_W-1:0] out_z;
      logic [DATA_W-1:0] out_w;
      logic              overflow;
   } rsp_type;

   // What one cell hands to the next: the transaction itself and the running sums.
   typedef struct packed {
      logic                       valid;
      logic                       action;
      logic [1:0]                 row;
      logic [1:0]                 col;
      logic [DATA_W-1:0]          coef;
      logic [DIM-1:0][DATA_W-1:0] vec;
      logic [DIM-1:0][SUM_W-1:0]  acc;
   } cell_bus_type;

endpackage

// ===== rtl/core/hvt_cell.sv =====
// One matrix column cell: holds four coefficients, multiplies and accumulates.
module hvt_cell #(
   parameter logic [1:0] COL = 2'd0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  hvt_pkg::cell_bus_type bus_in,
   output hvt_pkg::cell_bus_type bus_out
);

   logic [hvt_pkg::DIM-1:0][hvt_pkg::DATA_W-1:0] coef_ff, coef_in;
   logic [hvt_pkg::DIM-1:0][hvt_pkg::PROD_W-1:0] prod_ff, prod_in;
   hvt_pkg::cell_bus_type                        mid_ff, mid_in;
   hvt_pkg::cell_bus_type                        out_ff, out_in;

   // A load passing this cell updates the column it owns.
   always_comb begin
      coef_in = coef_ff;
      if (bus_in.valid && bus_in.action == hvt_pkg::ACT_LOAD && bus_in.col == COL) begin
         coef_in[bus_in.row] = bus_in.coef;
      end
   end

   always_comb begin
      mid_in = bus_in;
      for (int r = 0; r < hvt_pkg::DIM; r++) begin
         prod_in[r] = $signed({{hvt_pkg::DATA_W{coef_ff[r][hvt_pkg::DATA_W-1]}}, coef_ff[r]})
                    * $signed({{hvt_pkg::DATA_W{bus_in.vec[COL][hvt_pkg::DATA_W-1]}},
                               bus_in.vec[COL]});
      end
   end

   always_comb begin
      out_in = mid_ff;
      for (int r = 0; r < hvt_pkg::DIM; r++) begin
         out_in.acc[r] = mid_ff.acc[r] + {{2{prod_ff[r][hvt_pkg::PROD_W-1]}}, prod_ff[r]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff      <= '0;
         mid_ff.valid <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (enable) begin
         coef_ff <= coef_in;
         mid_ff  <= mid_in;
         prod_ff <= prod_in;
         out_ff  <= out_in;
      end
   end

   assign bus_out = out_ff;

endmodule

// ===== rtl/core/hvt_out.sv =====
// Output stage: rescales the exact sums, saturates and holds the result register.
module hvt_out #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  hvt_pkg::cell_bus_type bus_in,
   output logic                  rsp_valid,
   output hvt_pkg::rsp_type      rsp_data
);

   logic                                         rsp_valid_ff, rsp_valid_in;
   hvt_pkg::rsp_type                             rsp_data_ff, rsp_data_in;
   logic signed [hvt_pkg::SUM_W-1:0]             scaled;
   logic [hvt_pkg::SUM_W-1:hvt_pkg::DATA_W-1]    top_bits;
   logic [hvt_pkg::DIM-1:0][hvt_pkg::DATA_W-1:0] comp;
   logic [hvt_pkg::DIM-1:0]                      sat;

   always_comb begin
      scaled   = '0;
      top_bits = '0;
      for (int r = 0; r < hvt_pkg::DIM; r++) begin
         scaled   = $signed(bus_in.acc[r]) >>> FRAC_BITS;
         top_bits = scaled[hvt_pkg::SUM_W-1:hvt_pkg::DATA_W-1];
         // The value fits when every bit above the 32-bit sign agrees with it.
         sat[r]   = !((&top_bits) || !(|top_bits));
         if (sat[r]) begin
            comp[r] = scaled[hvt_pkg::SUM_W-1] ? hvt_pkg::SAT_MIN : hvt_pkg::SAT_MAX;
         end else begin
            comp[r] = scaled[hvt_pkg::DATA_W-1:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in         = bus_in.valid && bus_in.action == hvt_pkg::ACT_XFORM;
      rsp_data_in.out_x    = comp[0];
      rsp_data_in.out_y    = comp[1];
      rsp_data_in.out_z    = comp[2];
      rsp_data_in.out_w    = comp[3];
      rsp_data_in.overflow = |sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/homogeneous_vertex_transform.sv =====
// Top level of the homogeneous vertex transform: a chain of four column cells.
//
// Usage. Transactions enter on the req_ channel (req_valid, req_stall, req_data).
// A load transaction (action 0) writes one Q16.16 coefficient at row and column
// and gives no result. A transform transaction (action 1) carries a vertex and
// gives one result on the rsp_ channel: the four row dot products of the stored
// matrix with the vertex, shifted down by FRAC_BITS, saturated, with a flag.
// Throughput is one transaction per cycle unless the receiver stalls a waiting
// result, loads and transforms mixed freely. Each of the four column cells
// registers its products and then its sums, and the output stage registers the
// result.
// Loads travel down the chain with the transforms, so each transform sees
// exactly the loads accepted before it.
// Reset clears the matrix to zero and empties the pipeline.
// When the receiver stalls a waiting result, the whole chain holds and
// req_stall rises in the same cycle; otherwise new transactions are taken even
// while a result sits in the output register.
module homogeneous_vertex_transform #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hvt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hvt_pkg::rsp_type rsp_data
);

   // The chain advances unless a finished result is held back by the receiver.
   logic                  enable;
   hvt_pkg::cell_bus_type chain [hvt_pkg::DIM+1];

   assign enable    = !(rsp_valid && rsp_stall);
   assign req_stall = !enable;

   // Entry of the chain: the transaction as received, with the sums cleared.
   always_comb begin
      chain[0].valid  = req_valid;
      chain[0].action = req_data.action;
      chain[0].row    = req_data.row;
      chain[0].col    = req_data.col;
      chain[0].coef   = req_data.coef;
      chain[0].vec[0] = req_data.in_x;
      chain[0].vec[1] = req_data.in_y;
      chain[0].vec[2] = req_data.in_z;
      chain[0].vec[3] = req_data.in_w;
      chain[0].acc    = '0;
   end

   // Cell c owns matrix column c and adds its products to all four row sums.
   for (genvar c = 0; c < hvt_pkg::DIM; c++) begin : g_cell
      hvt_cell #(
         .COL (2'(c))
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .bus_in  (chain[c]),
         .bus_out (chain[c+1])
      );
   end

   hvt_out #(
      .FRAC_BITS (FRAC_BITS)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .bus_in    (chain[hvt_pkg::DIM]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== verif/hvt_result_checker.sv =====
// Result checker for the homogeneous vertex transform: shadow matrix, prediction and compare.
`timescale 1ns / 1ps

module hvt_result_checker #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  hvt_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  hvt_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);

   localparam int REPORT_LIMIT = 10;

   logic [hvt_pkg::DATA_W-1:0] shadow_matrix [hvt_pkg::DIM*hvt_pkg::DIM];
   hvt_pkg::rsp_type           expected_vertices [$];

   // Exact row sums, floor shift by FRAC_BITS, then saturation to 32 bits.
   function automatic hvt_pkg::rsp_type transform_vertex(hvt_pkg::req_type t);
      hvt_pkg::rsp_type                  r;
      logic signed [hvt_pkg::DATA_W-1:0] v [hvt_pkg::DIM];
      logic signed [hvt_pkg::DATA_W-1:0] c;
      logic signed [hvt_pkg::SUM_W-1:0]  sum;
      logic signed [hvt_pkg::SUM_W-1:0]  q;
      logic [hvt_pkg::DATA_W-1:0]        res [hvt_pkg::DIM];
      logic                              ovf;
      v[0] = t.in_x;
      v[1] = t.in_y;
      v[2] = t.in_z;
      v[3] = t.in_w;
      ovf  = 1'b0;
      for (int i = 0; i < hvt_pkg::DIM; i++) begin
         sum = '0;
         for (int j = 0; j < hvt_pkg::DIM; j++) begin
            c   = shadow_matrix[{2'(i), 2'(j)}];
            sum = sum + c * v[j];
         end
         q = sum >>> FRAC_BITS;
         if (q[hvt_pkg::SUM_W-1:hvt_pkg::DATA_W-1] == '0 ||
             q[hvt_pkg::SUM_W-1:hvt_pkg::DATA_W-1] == '1) begin
            res[i] = q[hvt_pkg::DATA_W-1:0];
         end else begin
            ovf    = 1'b1;
            res[i] = q[hvt_pkg::SUM_W-1] ? hvt_pkg::SAT_MIN : hvt_pkg::SAT_MAX;
         end
      end
      r.out_x    = res[0];
      r.out_y    = res[1];
      r.out_z    = res[2];
      r.out_w    = res[3];
      r.overflow = ovf;
      return r;
   endfunction

   always @(posedge clock) begin
      hvt_pkg::rsp_type want;
      if (reset) begin
         foreach (shadow_matrix[i]) shadow_matrix[i] = '0;
         expected_vertices.delete();
      end else begin
         // Results first: a transaction accepted at this edge cannot answer at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (expected_vertices.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: result with nothing expected: x=%h y=%h z=%h w=%h ovf=%b",
                           $realtime, rsp_data.out_x, rsp_data.out_y, rsp_data.out_z,
                           rsp_data.out_w, rsp_data.overflow);
            end else begin
               want = expected_vertices.pop_front();
               if (rsp_data.out_x !== want.out_x || rsp_data.out_y !== want.out_y ||
                   rsp_data.out_z !== want.out_z || rsp_data.out_w !== want.out_w ||
                   rsp_data.overflow !== want.overflow) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("%0t: mismatch, expected x=%h y=%h z=%h w=%h ovf=%b", $realtime,
                              want.out_x, want.out_y, want.out_z, want.out_w, want.overflow);
                     $display("%0t:           actual   x=%h y=%h z=%h w=%h ovf=%b", $realtime,
                              rsp_data.out_x, rsp_data.out_y, rsp_data.out_z, rsp_data.out_w,
                              rsp_data.overflow);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_data.action == hvt_pkg::ACT_LOAD)
               shadow_matrix[{req_data.row, req_data.col}] = req_data.coef;
            else
               expected_vertices.insert(expected_vertices.size(), transform_vertex(req_data));
         end
      end
      pending_count = expected_vertices.size();
   end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top of the homogeneous vertex transform: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned FRAC_BITS    = 16;
   // The drain outlasts the latency of the pipeline.
   localparam int          DRAIN_CYCLES = 32;
   // The long hold-off on the result side, well beyond the depth of the pipeline.
   localparam int          HOLD_CYCLES  = 200;
   localparam logic [hvt_pkg::DATA_W-1:0] Q_ONE  = 32'h0001_0000;
   localparam logic [hvt_pkg::DATA_W-1:0] Q_HALF = 32'h0000_8000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   hvt_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   hvt_pkg::rsp_type rsp_data;

   int fail_count;
   int pending_count;

   // Idle rates in percent, changed by the stimulus between phases.
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;

   // The stimulus raises the trigger once; the receiver process does the counting.
   bit hold_trigger = 1'b0;
   bit hold_done    = 1'b0;
   int hold_count;

   homogeneous_vertex_transform #(
      .FRAC_BITS(FRAC_BITS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   hvt_result_checker #(
      .FRAC_BITS(FRAC_BITS)
   ) u_result_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   // 10 ns clock period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A Q16.16 value drawn mostly from modest magnitudes, so that many dot products
   // stay in range, with full-width values and the extremes mixed in to reach
   // every bit and the saturation paths.
   function automatic logic [hvt_pkg::DATA_W-1:0] random_q16();
      logic [hvt_pkg::DATA_W-1:0] val;
      case ($urandom_range(0, 19))
         0, 1, 2, 3: val = $urandom;
         4, 5, 6: begin
            case ($urandom_range(0, 5))
               0:       val = '0;
               1:       val = 32'h0000_0001;
               2:       val = 32'hFFFF_FFFF;
               3:       val = hvt_pkg::SAT_MAX;
               4:       val = hvt_pkg::SAT_MIN;
               default: val = Q_ONE;
            endcase
         end
         7, 8, 9: val = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
         default: val = $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
      endcase
      return val;
   endfunction

   // A load transaction; the vertex fields carry noise, which the block must ignore.
   function automatic hvt_pkg::req_type make_load(logic [1:0] row, logic [1:0] col,
                                                  logic [hvt_pkg::DATA_W-1:0] coef);
      hvt_pkg::req_type t;
      t.action = hvt_pkg::ACT_LOAD;
      t.row    = row;
      t.col    = col;
      t.coef   = coef;
      t.in_x   = $urandom;
      t.in_y   = $urandom;
      t.in_z   = $urandom;
      t.in_w   = $urandom;
      return t;
   endfunction

   // A transform transaction; row, column and coefficient carry noise.
   function automatic hvt_pkg::req_type make_xform(logic [hvt_pkg::DATA_W-1:0] x,
                                                   logic [hvt_pkg::DATA_W-1:0] y,
                                                   logic [hvt_pkg::DATA_W-1:0] z,
                                                   logic [hvt_pkg::DATA_W-1:0] w);
      hvt_pkg::req_type t;
      t.action = hvt_pkg::ACT_XFORM;
      t.row    = 2'($urandom_range(0, 3));
      t.col    = 2'($urandom_range(0, 3));
      t.coef   = $urandom;
      t.in_x   = x;
      t.in_y   = y;
      t.in_z   = z;
      t.in_w   = w;
      return t;
   endfunction

   // Roughly seven transforms to every three loads, so the matrix keeps changing
   // under a steady stream of results.
   function automatic hvt_pkg::req_type random_transaction();
      hvt_pkg::req_type t;
      t.action = ($urandom_range(0, 99) < 30) ? hvt_pkg::ACT_LOAD : hvt_pkg::ACT_XFORM;
      t.row    = 2'($urandom_range(0, 3));
      t.col    = 2'($urandom_range(0, 3));
      t.coef   = random_q16();
      t.in_x   = random_q16();
      t.in_y   = random_q16();
      t.in_z   = random_q16();
      t.in_w   = random_q16();
      return t;
   endfunction

   // Offers one transaction from a falling edge, after an optional random gap,
   // and holds it steady until a rising edge sees it taken. Valid is only ever
   // lowered for a gap, never in the step where the next transaction goes up.
   task automatic send_transaction(hvt_pkg::req_type t);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic run_random_phase(int count);
      for (int n = 0; n < count; n++) send_transaction(random_transaction());
   endtask

   // Receiver: stalls at random at the current rate, except once for a long
   // stretch when the stimulus asks for it, so that the pipeline fills and the
   // block has to stall its input side.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_trigger && !hold_done) begin
            hold_done = 1'b1;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
               rsp_stall = 1'b1;
               @(negedge clock);
            end
         end else begin
            rsp_stall = ($urandom_range(0, 99) < receiver_idle_pct);
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, under the first idle setting.
      sender_idle_pct   = 16;
      receiver_idle_pct = 63;

      // The matrix is all zero after reset, so any vertex must come back as zero.
      send_transaction(make_xform(hvt_pkg::SAT_MAX, hvt_pkg::SAT_MIN, 32'hFFFF_FFFF,
                                  32'h0000_0000));

      // Identity matrix: extreme vertex components pass through unchanged.
      for (int r = 0; r < 4; r++) send_transaction(make_load(2'(r), 2'(r), Q_ONE));
      send_transaction(make_xform(hvt_pkg::SAT_MIN, hvt_pkg::SAT_MAX, 32'h0000_0001,
                                  32'hFFFF_FFFF));

      // Row 0 all most positive, row 1 all most negative, row 2 mixed extremes,
      // row 3 scaled down to one half on w to exercise the floor on odd values.
      for (int c = 0; c < 4; c++) send_transaction(make_load(2'd0, 2'(c), hvt_pkg::SAT_MAX));
      for (int c = 0; c < 4; c++) send_transaction(make_load(2'd1, 2'(c), hvt_pkg::SAT_MIN));
      send_transaction(make_load(2'd2, 2'd0, hvt_pkg::SAT_MAX));
      send_transaction(make_load(2'd2, 2'd1, hvt_pkg::SAT_MIN));
      send_transaction(make_load(2'd2, 2'd2, 32'h0000_0001));
      send_transaction(make_load(2'd2, 2'd3, 32'hFFFF_FFFF));
      send_transaction(make_load(2'd3, 2'd3, Q_HALF));

      // Positive overflow on row 0 and negative on row 1, then the reverse; the
      // all-minimum vertex gives the largest exact sum the block can see.
      send_transaction(make_xform(hvt_pkg::SAT_MAX, hvt_pkg::SAT_MAX, hvt_pkg::SAT_MAX,
                                  hvt_pkg::SAT_MAX));
      send_transaction(make_xform(hvt_pkg::SAT_MIN, hvt_pkg::SAT_MIN, hvt_pkg::SAT_MIN,
                                  hvt_pkg::SAT_MIN));
      // Small odd and negative values, where truncation must round toward minus infinity.
      send_transaction(make_xform(32'h0000_0003, 32'hFFFF_FFFD, 32'h0001_8000, 32'hFFFF_FFFF));

      // Random part: first a mostly stalled receiver, then a mostly idle sender.
      run_random_phase(420);
      sender_idle_pct   = 63;
      receiver_idle_pct = 16;
      run_random_phase(420);

      // Full rate with no idling on either side, interrupted once by the long
      // hold-off while the sender keeps offering transactions.
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      run_random_phase(60);
      hold_trigger = 1'b1;
      run_random_phase(350);

      @(negedge clock);
      req_valid = 1'b0;

      // Wait for every expected result, then give the pipeline time to show any
      // stray one.
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("** homogeneous_vertex_transform: PASSED **");
      end else begin
         $display("** homogeneous_vertex_transform: FAILED **");
      end
      $finish;
   end

   // Guard against a hung handshake: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("** homogeneous_vertex_transform: FAILED **");
      $finish;
   end

endmodule

// ===== homogeneous_vertex_transform.f =====
rtl/core/hvt_pkg.sv
rtl/core/hvt_cell.sv
rtl/core/hvt_out.sv
rtl/core/homogeneous_vertex_transform.sv
verif/hvt_result_checker.sv
verif/tb_top.sv
